/* hw/rtl/jts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_pkg
// Shared types, codes and character tables for the JSON token scanner.
// ----------------------------------------------------------------------------
package jts_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LINE_BITS   = 24;
    localparam int KIND_BITS   = 4;
    localparam int MAX_RES     = 3;
    localparam int NUM_SLOTS   = 4;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    // token kinds
    typedef enum logic [KIND_BITS-1:0] {
        KIND_EOF     = 4'd0,
        KIND_LBRACE  = 4'd1,
        KIND_RBRACE  = 4'd2,
        KIND_LBRACK  = 4'd3,
        KIND_RBRACK  = 4'd4,
        KIND_COMMA   = 4'd5,
        KIND_COLON   = 4'd6,
        KIND_STRING  = 4'd7,
        KIND_NUMBER  = 4'd8,
        KIND_BOOL    = 4'd9,
        KIND_NULL    = 4'd10,
        KIND_ILLEGAL = 4'd11
    } t_kind;

    // scanner modes, one-hot
    typedef enum logic [11:0] {
        M_IDLE  = 12'b0000_0000_0001,
        M_STR   = 12'b0000_0000_0010,
        M_ESC   = 12'b0000_0000_0100,
        M_HEX   = 12'b0000_0000_1000,
        M_NSIGN = 12'b0000_0001_0000,
        M_NINT  = 12'b0000_0010_0000,
        M_NDOT  = 12'b0000_0100_0000,
        M_NFRAC = 12'b0000_1000_0000,
        M_NEXP  = 12'b0001_0000_0000,
        M_NEXPS = 12'b0010_0000_0000,
        M_NEXPD = 12'b0100_0000_0000,
        M_KEYW  = 12'b1000_0000_0000
    } t_mode;

    // keyword selectors
    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;

    // character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UE     = 8'h45;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LE     = 8'h65;
    localparam logic [7:0] CH_LF_CH  = 8'h66;
    localparam logic [7:0] CH_LL     = 8'h6C;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LS     = 8'h73;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LU     = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // one result item
    typedef struct packed {
        t_kind                  token_kind;
        logic [OFFSET_BITS-1:0] span_start;
        logic [OFFSET_BITS-1:0] span_end;
        logic [LINE_BITS-1:0]   line_no;
        logic                   truth_value;
        logic                   run_last;
    } t_token;

    // candidate result of one byte
    typedef struct packed {
        logic   valid;
        t_token tok;
    } t_slot;

    // keyword letters by keyword and position
    function automatic logic [7:0] kw_char(input logic [1:0] w, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (w)
            KW_TRUE: begin
                case (pos)
                    3'd0:    c = CH_LT;
                    3'd1:    c = CH_LR;
                    3'd2:    c = CH_LU;
                    3'd3:    c = CH_LE;
                    default: c = 8'h00;
                endcase
            end
            KW_FALSE: begin
                case (pos)
                    3'd0:    c = CH_LF_CH;
                    3'd1:    c = CH_LA;
                    3'd2:    c = CH_LL;
                    3'd3:    c = CH_LS;
                    3'd4:    c = CH_LE;
                    default: c = 8'h00;
                endcase
            end
            default: begin
                case (pos)
                    3'd0:    c = CH_LN;
                    3'd1:    c = CH_LU;
                    3'd2:    c = CH_LL;
                    3'd3:    c = CH_LL;
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

    // keyword lengths
    function automatic logic [2:0] kw_len(input logic [1:0] w);
        return (w == KW_FALSE) ? 3'd5 : 3'd4;
    endfunction

endpackage

/* hw/rtl/jts_byte_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_byte_if
// Text byte channel: valid/ready with one byte and an end-of-text mark.
// ----------------------------------------------------------------------------
interface jts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

/* hw/rtl/jts_token_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_token_if
// Token channel: valid/ready with kind, span, line and flags.
// ----------------------------------------------------------------------------
interface jts_token_if
    import jts_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [KIND_BITS-1:0]   token_kind;
    logic [OFFSET_BITS-1:0] span_start;
    logic [OFFSET_BITS-1:0] span_end;
    logic [LINE_BITS-1:0]   line_no;
    logic                   truth_value;
    logic                   run_last;

    modport source (output valid, output token_kind, output span_start, output span_end,
                    output line_no, output truth_value, output run_last, input ready);
    modport sink   (input valid, input token_kind, input span_start, input span_end,
                    input line_no, input truth_value, input run_last, output ready);
endinterface

/* hw/rtl/jts_lex_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_lex_core
// Scanner state and the single-pass lexing of one byte into up to three tokens.
// ----------------------------------------------------------------------------
module jts_lex_core
    import jts_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [7:0]                  i_text_byte,
    input  logic                        i_end_of_text,
    output t_slot [NUM_SLOTS-1:0]       o_slots
);

    t_mode                  r_mode,       n_mode;
    logic [OFFSET_BITS-1:0] r_offset,     n_offset;
    logic [OFFSET_BITS-1:0] r_begin,      n_begin;
    logic [LINE_BITS-1:0]   r_line_cnt,   n_line_cnt;
    logic [LINE_BITS-1:0]   r_tok_line,   n_tok_line;
    logic [1:0]             r_kw_which,   n_kw_which;
    logic [2:0]             r_kw_pos,     n_kw_pos;
    logic [2:0]             r_hex_left,   n_hex_left;
    logic                   r_bad,        n_bad;

    function automatic logic is_num_mode(input t_mode m);
        return (m == M_NSIGN) || (m == M_NINT) || (m == M_NDOT) || (m == M_NFRAC) ||
               (m == M_NEXP) || (m == M_NEXPS) || (m == M_NEXPD);
    endfunction

    function automatic logic num_ok(input t_mode m, input logic bad);
        return !bad && ((m == M_NINT) || (m == M_NFRAC) || (m == M_NEXPD));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || ((b >= CH_LA) && (b <= CH_LF_CH)) ||
               ((b >= CH_UA) && (b <= CH_UF));
    endfunction

    function automatic logic is_num_byte(input logic [7:0] b);
        return is_digit(b) || (b == CH_DOT) || (b == CH_LE) || (b == CH_UE) ||
               (b == CH_PLUS) || (b == CH_MINUS);
    endfunction

    // next number mode, or idle when the byte breaks the grammar
    function automatic t_mode num_next(input t_mode m, input logic [7:0] b);
        logic  d;
        logic  ex;
        logic  sg;
        t_mode nx;
        d  = is_digit(b);
        ex = (b == CH_LE) || (b == CH_UE);
        sg = (b == CH_PLUS) || (b == CH_MINUS);
        nx = M_IDLE;
        case (m)
            M_NSIGN: if (d) nx = M_NINT;
            M_NINT: begin
                if (d)                nx = M_NINT;
                else if (b == CH_DOT) nx = M_NDOT;
                else if (ex)          nx = M_NEXP;
            end
            M_NDOT:  if (d) nx = M_NFRAC;
            M_NFRAC: begin
                if (d)       nx = M_NFRAC;
                else if (ex) nx = M_NEXP;
            end
            M_NEXP: begin
                if (d)       nx = M_NEXPD;
                else if (sg) nx = M_NEXPS;
            end
            M_NEXPS: if (d) nx = M_NEXPD;
            default: if (d) nx = M_NEXPD;
        endcase
        return nx;
    endfunction

    function automatic t_token mk_tok(input t_kind k, input logic [OFFSET_BITS-1:0] s,
                                      input logic [OFFSET_BITS-1:0] f,
                                      input logic [LINE_BITS-1:0] ln, input logic tv);
        t_token t;
        t.token_kind  = k;
        t.span_start  = s;
        t.span_end    = f;
        t.line_no     = ln;
        t.truth_value = tv;
        t.run_last    = 1'b0;
        return t;
    endfunction

    // one byte through the scanner
    always_comb begin
        logic [7:0]             b;
        logic [OFFSET_BITS-1:0] e;
        logic                   relex;
        logic [1:0]             w;
        logic [2:0]             pos_inc;
        t_mode                  nx;
        t_kind                  pk;
        logic                   seen;
        t_slot [NUM_SLOTS-1:0]  sl;

        b          = i_text_byte;
        e          = r_offset + 1'b1;
        relex      = 1'b0;
        w          = (r_kw_which == 2'd3) ? KW_NULL : r_kw_which;
        pos_inc    = r_kw_pos + 3'd1;
        nx         = M_IDLE;
        pk         = KIND_ILLEGAL;
        seen       = 1'b0;
        sl         = '0;
        n_mode     = r_mode;
        n_offset   = r_offset;
        n_begin    = r_begin;
        n_line_cnt = r_line_cnt;
        n_tok_line = r_tok_line;
        n_kw_which = r_kw_which;
        n_kw_pos   = r_kw_pos;
        n_hex_left = r_hex_left;
        n_bad      = r_bad;

        if (i_go) begin
            // continue the open token
            unique case (r_mode)
                M_IDLE: relex = 1'b1;
                M_STR: begin
                    if (b == CH_BSLASH) begin
                        n_mode = M_ESC;
                    end else if (b == CH_QUOTE) begin
                        sl[0].valid = 1'b1;
                        sl[0].tok   = mk_tok(r_bad ? KIND_ILLEGAL : KIND_STRING, r_begin, e,
                                             r_tok_line, 1'b0);
                        n_mode = M_IDLE;
                    end
                end
                M_ESC: begin
                    if (b == CH_LU) begin
                        n_mode     = M_HEX;
                        n_hex_left = 3'd4;
                    end else begin
                        if (!((b == CH_QUOTE) || (b == CH_BSLASH) || (b == CH_SLASH) ||
                              (b == CH_LB) || (b == CH_LF_CH) || (b == CH_LN) ||
                              (b == CH_LR) || (b == CH_LT)))
                            n_bad = 1'b1;
                        n_mode = M_STR;
                    end
                end
                M_HEX: begin
                    if (!is_hex(b))
                        n_bad = 1'b1;
                    n_hex_left = r_hex_left - 3'd1;
                    if (n_hex_left == 3'd0)
                        n_mode = M_STR;
                end
                M_KEYW: begin
                    if ((r_kw_pos < kw_len(w)) && (b == kw_char(w, r_kw_pos))) begin
                        n_kw_pos = pos_inc;
                        if (pos_inc == kw_len(w)) begin
                            sl[0].valid = 1'b1;
                            sl[0].tok   = mk_tok((w == KW_NULL) ? KIND_NULL : KIND_BOOL,
                                                 r_begin, e, r_tok_line, w == KW_TRUE);
                            n_mode = M_IDLE;
                        end
                    end else begin
                        sl[0].valid = 1'b1;
                        sl[0].tok   = mk_tok(KIND_ILLEGAL, r_begin, r_offset, r_tok_line, 1'b0);
                        n_mode = M_IDLE;
                        relex  = 1'b1;
                    end
                end
                M_NSIGN, M_NINT, M_NDOT, M_NFRAC, M_NEXP, M_NEXPS, M_NEXPD: begin
                    if (is_num_byte(b)) begin
                        nx = num_next(r_mode, b);
                        if (nx == M_IDLE)
                            n_bad = 1'b1;
                        else
                            n_mode = nx;
                    end else begin
                        sl[0].valid = 1'b1;
                        sl[0].tok   = mk_tok(num_ok(r_mode, r_bad) ? KIND_NUMBER : KIND_ILLEGAL,
                                             r_begin, r_offset, r_tok_line, 1'b0);
                        n_mode = M_IDLE;
                        relex  = 1'b1;
                    end
                end
                default: begin
                    n_mode = M_IDLE;
                    relex  = 1'b1;
                end
            endcase

            // lex the byte as the start of something new
            if (relex) begin
                case (b) inside
                    CH_SPACE, CH_TAB, CH_CR: begin
                    end
                    CH_LF: begin
                        if (r_line_cnt != {LINE_BITS{1'b1}})
                            n_line_cnt = r_line_cnt + 1'b1;
                    end
                    CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COMMA, CH_COLON: begin
                        case (b)
                            CH_LBRACE: pk = KIND_LBRACE;
                            CH_RBRACE: pk = KIND_RBRACE;
                            CH_LBRACK: pk = KIND_LBRACK;
                            CH_RBRACK: pk = KIND_RBRACK;
                            CH_COMMA:  pk = KIND_COMMA;
                            default:   pk = KIND_COLON;
                        endcase
                        sl[1].valid = 1'b1;
                        sl[1].tok   = mk_tok(pk, r_offset, e, r_line_cnt, 1'b0);
                    end
                    CH_QUOTE: begin
                        n_mode     = M_STR;
                        n_begin    = r_offset;
                        n_tok_line = r_line_cnt;
                        n_bad      = 1'b0;
                    end
                    CH_LT, CH_LF_CH, CH_LN: begin
                        n_mode     = M_KEYW;
                        n_begin    = r_offset;
                        n_tok_line = r_line_cnt;
                        n_bad      = 1'b0;
                        n_kw_pos   = 3'd1;
                        n_kw_which = (b == CH_LT) ? KW_TRUE :
                                     (b == CH_LF_CH) ? KW_FALSE : KW_NULL;
                    end
                    [CH_0:CH_9], CH_MINUS: begin
                        n_mode     = (b == CH_MINUS) ? M_NSIGN : M_NINT;
                        n_begin    = r_offset;
                        n_tok_line = r_line_cnt;
                        n_bad      = 1'b0;
                    end
                    default: begin
                        sl[1].valid = 1'b1;
                        sl[1].tok   = mk_tok(KIND_ILLEGAL, r_offset, e, r_line_cnt, 1'b0);
                    end
                endcase
            end

            // end of text: close what is open, add eof, start over
            if (i_end_of_text) begin
                if (n_mode != M_IDLE) begin
                    sl[2].valid = 1'b1;
                    sl[2].tok   = mk_tok((is_num_mode(n_mode) && num_ok(n_mode, n_bad)) ?
                                         KIND_NUMBER : KIND_ILLEGAL,
                                         n_begin, e, n_tok_line, 1'b0);
                end
                sl[3].valid = 1'b1;
                sl[3].tok   = mk_tok(KIND_EOF, e, e + 1'b1, n_line_cnt, 1'b0);
                n_mode     = M_IDLE;
                n_offset   = '0;
                n_begin    = '0;
                n_line_cnt = LINE_BITS'(1);
                n_tok_line = LINE_BITS'(1);
                n_kw_which = 2'd0;
                n_kw_pos   = 3'd0;
                n_hex_left = 3'd0;
                n_bad      = 1'b0;
            end else begin
                n_offset = e;
            end
        end

        // mark the last token of this byte
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (sl[i].valid && !seen) begin
                sl[i].tok.run_last = 1'b1;
                seen = 1'b1;
            end
        end
        o_slots = sl;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_IDLE;
            r_offset   <= '0;
            r_begin    <= '0;
            r_line_cnt <= LINE_BITS'(1);
            r_tok_line <= LINE_BITS'(1);
            r_kw_which <= 2'd0;
            r_kw_pos   <= 3'd0;
            r_hex_left <= 3'd0;
            r_bad      <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_offset   <= n_offset;
            r_begin    <= n_begin;
            r_line_cnt <= n_line_cnt;
            r_tok_line <= n_tok_line;
            r_kw_which <= n_kw_which;
            r_kw_pos   <= n_kw_pos;
            r_hex_left <= n_hex_left;
            r_bad      <= n_bad;
        end
    end

endmodule

/* hw/rtl/jts_tok_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_tok_fifo
// Small token queue: takes up to three tokens a cycle, gives one a cycle.
// ----------------------------------------------------------------------------
module jts_tok_fifo
    import jts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_slot [NUM_SLOTS-1:0] i_slots,
    input  logic                  i_pop,
    output logic                  o_room,
    output logic                  o_valid,
    output t_token                o_head
);

    t_token               r_mem [FIFO_DEPTH];
    t_token               n_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FIFO_AW:0]     r_count,  n_count;
    logic [FIFO_AW:0]     push_cnt;

    // room for the most tokens one byte can cause
    assign o_room  = (r_count <= (FIFO_AW + 1)'(FIFO_DEPTH - MAX_RES));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // pack the valid slots in order behind the write pointer
    always_comb begin
        logic [FIFO_AW-1:0] idx;
        idx      = '0;
        push_cnt = '0;
        n_mem    = r_mem;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (i_slots[i].valid) begin
                idx        = r_wr_ptr + push_cnt[FIFO_AW-1:0];
                n_mem[idx] = i_slots[i].tok;
                push_cnt   = push_cnt + 1'b1;
            end
        end
        n_wr_ptr = r_wr_ptr + push_cnt[FIFO_AW-1:0];
        n_rd_ptr = r_rd_ptr + (FIFO_AW)'(i_pop);
        n_count  = r_count + push_cnt - (FIFO_AW + 1)'(i_pop);
    end

    // token storage
    always_ff @(posedge i_clk) begin
        r_mem <= n_mem;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* hw/rtl/json_token_scanner_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_token_scanner_top
// Streaming JSON tokenizer: one text byte in, kind/span/line tokens out.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  i_byte   | in  | valid/ready   | text_byte[7:0], end_of_text
//  o_tok    | out | valid/ready   | token_kind[3:0], span_start[31:0], span_end[31:0],
//           |     |               | line_no[23:0], truth_value, run_last
//
//  One byte is taken per cycle while the queue has room. A byte is registered,
//  lexed combinationally by the scanner and its 0 to 3 tokens are written to a
//  four-entry token queue. A byte is lexed only when the queue has three free
//  entries, so bytes that cause several tokens can hold later bytes back.
//  A token is offered once its byte is lexed and queued. Reset is
//  synchronous and leaves the scanner between tokens at offset 0, line 1.
//  A stalled output fills the queue and then holds i_byte.ready low.
// ----------------------------------------------------------------------------
module json_token_scanner_top
    import jts_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    jts_byte_if.sink        i_byte,
    jts_token_if.source     o_tok
);

    logic                  r_in_vld;
    logic [7:0]            r_in_byte;
    logic                  r_in_eot;
    logic                  go;
    logic                  room;
    logic                  head_vld;
    t_token                head;
    t_slot [NUM_SLOTS-1:0] slots;

    // lex the held byte when the queue can take its tokens
    assign go           = r_in_vld && room;
    assign i_byte.ready = !r_in_vld || go;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_vld <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.text_byte;
            r_in_eot  <= i_byte.end_of_text;
        end
    end

    // scanner
    jts_lex_core u_lex (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (go),
        .i_text_byte   (r_in_byte),
        .i_end_of_text (r_in_eot),
        .o_slots       (slots)
    );

    // token queue
    jts_tok_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slots (slots),
        .i_pop   (head_vld && o_tok.ready),
        .o_room  (room),
        .o_valid (head_vld),
        .o_head  (head)
    );

    // output channel
    assign o_tok.valid       = head_vld;
    assign o_tok.token_kind  = head.token_kind;
    assign o_tok.span_start  = head.span_start;
    assign o_tok.span_end    = head.span_end;
    assign o_tok.line_no     = head.line_no;
    assign o_tok.truth_value = head.truth_value;
    assign o_tok.run_last    = head.run_last;

endmodule

/* hw/rtl/jts_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_checker
// Port-level checks on the token channel of the JSON token scanner.
// ----------------------------------------------------------------------------
module jts_checker
    import jts_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [KIND_BITS-1:0]   i_kind,
    input  logic [OFFSET_BITS-1:0] i_start,
    input  logic [OFFSET_BITS-1:0] i_end,
    input  logic                   i_truth
);

    // a stalled token keeps its kind and span start
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) && $stable(i_start))
        else $error("token changed while stalled");

    // kinds stay within the defined codes
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_kind <= KIND_ILLEGAL))
        else $error("undefined token kind");

    // punctuation and eof cover exactly one byte
    a_one_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_kind == KIND_EOF) || (i_kind == KIND_LBRACE) ||
                        (i_kind == KIND_RBRACE) || (i_kind == KIND_LBRACK) ||
                        (i_kind == KIND_RBRACK) || (i_kind == KIND_COMMA) ||
                        (i_kind == KIND_COLON))
        |-> (i_end == i_start + 1'b1))
        else $error("single-byte token with wrong span");

    // truth flag only on bool tokens
    a_truth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_truth |-> (i_kind == KIND_BOOL))
        else $error("truth flag on non-bool token");

endmodule

bind json_token_scanner_top jts_checker u_jts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_tok.valid),
    .i_out_ready (o_tok.ready),
    .i_kind      (o_tok.token_kind),
    .i_start     (o_tok.span_start),
    .i_end       (o_tok.span_end),
    .i_truth     (o_tok.truth_value)
);
